>>> hw/rtl/jss_pkg.sv
// Shared types and constants for the JTAG scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

package jss_pkg;

   // Request opcodes
   localparam logic [2:0] OP_RESET  = 3'd0;
   localparam logic [2:0] OP_IR     = 3'd1;
   localparam logic [2:0] OP_DR     = 3'd2;
   localparam logic [2:0] OP_DETECT = 3'd3;
   localparam logic [2:0] OP_IRLEN  = 3'd4;
   localparam logic [2:0] OP_TICK   = 3'd5;

   // Report kinds
   localparam logic [2:0] RPT_NONE      = 3'd0;
   localparam logic [2:0] RPT_DR        = 3'd1;
   localparam logic [2:0] RPT_IDCODE    = 3'd2;
   localparam logic [2:0] RPT_IRLEN     = 3'd3;
   localparam logic [2:0] RPT_IRLEN_NF  = 3'd4;

   localparam int RESET_CLOCKS = 6;
   localparam int IR_PRE_CLOCKS = 4;
   localparam int DR_PRE_CLOCKS = 3;
   localparam int DATA_W = 32;
   localparam int LEN_W = 6;
   localparam logic [7:0] EOC_BYTE = 8'h01;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_RESET,
      CMD_IR,
      CMD_DR,
      CMD_DETECT,
      CMD_IRLEN
   } cmd_type;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_BODY,
      PH_POST
   } phase_type;

   typedef struct packed {
      logic              tms_out;
      logic              tdi_out;
      logic              busy_res;
      logic              sequence_done;
      logic [2:0]        report_kind;
      logic [DATA_W-1:0] report_value;
      logic [1:0]        device_index;
      logic              end_of_chain;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/jtag_scan_sequencer_core.sv
// JTAG scan sequencer: command decode, TAP walk, shift and capture, result buffering.
//
// Usage: send a command request (reset, IR scan, DR scan, chain walk, IR length
// probe) on the req_ channel, then one tick request per TCK clock carrying the
// TDO sampled for that clock. Each tick returns one result on the rsp_ channel:
// the TMS/TDI to present, busy/done flags and any report (DR word, IDCODE,
// IR length). Commands and unknown opcodes return nothing; a command sent
// while a sequence runs is dropped.
// A tick's result is registered into the result register, or into the skid entry when rsp_stall holds the output.
// Throughput: one request per cycle while req_stall is low; the whole tick is one pass of logic
// between the sequencer registers and the result register.
// The result register is backed by a one-entry skid buffer, so requests keep
// flowing while a result waits; req_stall rises only when the skid holds a
// result and falls the cycle after the receiver drains it.
// Reset (synchronous, active high) returns the sequencer to idle and empties
// both result entries; ticks while idle return an all-zero result.
`timescale 1ns / 1ps
`default_nettype none

module jtag_scan_sequencer_core
   import jss_pkg::*;
#(
   parameter int SCAN_WIDTH       = 32,
   parameter int DETECT_BIT_LIMIT = 100,
   parameter int IR_PROBE_LIMIT   = 30
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [DATA_W-1:0] req_shift_value,
   input  wire logic [LEN_W-1:0]  req_shift_length,
   input  wire logic              req_tdo_in,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_tms_out,
   output      logic              rsp_tdi_out,
   output      logic              rsp_busy_res,
   output      logic              rsp_sequence_done,
   output      logic [2:0]        rsp_report_kind,
   output      logic [DATA_W-1:0] rsp_report_value,
   output      logic [1:0]        rsp_device_index,
   output      logic              rsp_end_of_chain
);

   localparam int CNT_MAX0 = (DETECT_BIT_LIMIT > IR_PROBE_LIMIT) ?
                             DETECT_BIT_LIMIT : IR_PROBE_LIMIT;
   localparam int CNT_MAX  = (CNT_MAX0 > 64) ? CNT_MAX0 : 64;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);
   localparam int MW       = $clog2(IR_PROBE_LIMIT);
   localparam int IDX_W    = $clog2(DATA_W);

   // Sequencer state
   cmd_type           cmd_ff, cmd_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0]  id_cnt_ff, id_cnt_in;
   logic [1:0]        dev_ff, dev_in;
   logic              prev_tdo_ff, prev_tdo_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [MW-1:0]     irlen_ff, irlen_in;
   logic              irlen_found_ff, irlen_found_in;

   // Result buffer
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic             accept, take, produce;
   rsp_type          res;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W:0]   len_sat;
   logic [DATA_W-1:0] cap_next;
   logic             stop, done, irpath;

   assign accept  = req_valid && !req_stall;
   assign take    = out_valid_ff && !rsp_stall;
   assign cnt_inc = cnt_ff + CNT_W'(1);

   always_comb begin
      cmd_in         = cmd_ff;
      phase_in       = phase_ff;
      cnt_in         = cnt_ff;
      shift_in       = shift_ff;
      cap_in         = cap_ff;
      id_cnt_in      = id_cnt_ff;
      dev_in         = dev_ff;
      prev_tdo_in    = prev_tdo_ff;
      len_in         = len_ff;
      irlen_in       = irlen_ff;
      irlen_found_in = irlen_found_ff;
      res            = '0;
      produce        = 1'b0;
      stop           = 1'b0;
      done           = 1'b0;
      irpath         = (cmd_ff == CMD_IR) || (cmd_ff == CMD_IRLEN);
      cap_next       = cap_ff;
      len_sat        = '0;

      if (accept && req_opcode == OP_TICK) begin
         produce = 1'b1;
         if (cmd_ff != CMD_IDLE) begin
            res.busy_res = 1'b1;
            case (cmd_ff)
               CMD_RESET: begin
                  if (cnt_ff < CNT_W'(RESET_CLOCKS)) begin
                     res.tms_out = 1'b1;
                     cnt_in = cnt_inc;
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  case (phase_ff)
                     PH_PRE: begin
                        // IR path walks 1,1,0,0; DR path walks 1,0,0
                        res.tms_out = irpath ? (cnt_ff < CNT_W'(2)) : (cnt_ff < CNT_W'(1));
                        cnt_in = cnt_inc;
                        if (cnt_inc >= (irpath ? CNT_W'(IR_PRE_CLOCKS)
                                               : CNT_W'(DR_PRE_CLOCKS))) begin
                           phase_in = PH_BODY;
                           cnt_in = '0;
                        end
                     end
                     PH_BODY: begin
                        cnt_in = cnt_inc;
                        if (cmd_ff == CMD_IR || cmd_ff == CMD_DR) begin
                           res.tdi_out = shift_ff[0];
                           shift_in = shift_ff >> 1;
                           res.tms_out = (cnt_inc >= CNT_W'(len_ff));
                           if (cmd_ff == CMD_DR && cnt_ff < CNT_W'(DATA_W)) begin
                              cap_in = cap_ff | (DATA_W'(req_tdo_in) << cnt_ff[IDX_W-1:0]);
                           end
                           stop = res.tms_out;
                        end else if (cmd_ff == CMD_DETECT) begin
                           res.tdi_out = (cnt_ff == '0);
                           // skip a leading zero: device in bypass
                           if (id_cnt_ff != '0 || req_tdo_in) begin
                              cap_next = cap_ff | (DATA_W'(req_tdo_in) << id_cnt_ff);
                              cap_in = cap_next;
                              id_cnt_in = id_cnt_ff + IDX_W'(1);
                              if (id_cnt_ff == IDX_W'(DATA_W - 1)) begin
                                 res.report_kind = RPT_IDCODE;
                                 res.report_value = cap_next;
                                 res.device_index = dev_ff;
                                 res.end_of_chain = (cap_next[7:0] == EOC_BYTE);
                                 stop = res.end_of_chain;
                                 cap_in = '0;
                                 dev_in = dev_ff + 2'd1;
                              end
                           end
                           if (cnt_inc >= CNT_W'(DETECT_BIT_LIMIT)) begin
                              stop = 1'b1;
                           end
                        end else begin
                           res.tdi_out = (cnt_ff < CNT_W'(2));
                           if (cnt_ff == CNT_W'(1)) begin
                              prev_tdo_in = req_tdo_in;
                           end else if (cnt_ff >= CNT_W'(2)) begin
                              if (req_tdo_in && prev_tdo_ff) begin
                                 irlen_in = MW'(cnt_ff - CNT_W'(1));
                                 irlen_found_in = 1'b1;
                                 stop = 1'b1;
                              end
                              prev_tdo_in = req_tdo_in;
                           end
                           if (cnt_inc >= CNT_W'(IR_PROBE_LIMIT)) begin
                              stop = 1'b1;
                           end
                        end
                        if (stop) begin
                           phase_in = PH_POST;
                           cnt_in = '0;
                        end
                     end
                     default: begin
                        // Exit1 -> Update -> Idle; chain walk exits with TDI high
                        cnt_in = cnt_inc;
                        if (cmd_ff == CMD_IR || cmd_ff == CMD_DR) begin
                           res.tms_out = (cnt_inc < CNT_W'(2));
                           done = (cnt_inc >= CNT_W'(2));
                        end else begin
                           res.tms_out = (cnt_inc < CNT_W'(3));
                           done = (cnt_inc >= CNT_W'(3));
                        end
                        res.tdi_out = (cmd_ff == CMD_DETECT) && (cnt_ff == '0);
                        if (done && cmd_ff == CMD_DR) begin
                           res.report_kind = RPT_DR;
                           res.report_value = cap_ff;
                        end else if (done && cmd_ff == CMD_IRLEN) begin
                           if (irlen_found_ff) begin
                              res.report_kind = RPT_IRLEN;
                              res.report_value = DATA_W'(irlen_ff);
                           end else begin
                              res.report_kind = RPT_IRLEN_NF;
                           end
                        end
                     end
                  endcase
               end
            endcase
            if (done) begin
               res.busy_res = 1'b0;
               res.sequence_done = 1'b1;
               cmd_in = CMD_IDLE;
               phase_in = PH_PRE;
               cnt_in = '0;
            end
         end
      end else if (accept && cmd_ff == CMD_IDLE && req_opcode < OP_TICK) begin
         // saturate length: zero means one, cap at the scan width
         len_sat = (req_shift_length == '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(req_shift_length);
         if (len_sat > (CNT_W+1)'(SCAN_WIDTH)) begin
            len_sat = (CNT_W+1)'(SCAN_WIDTH);
         end
         case (req_opcode)
            OP_RESET:  cmd_in = CMD_RESET;
            OP_IR:     cmd_in = CMD_IR;
            OP_DR:     cmd_in = CMD_DR;
            OP_DETECT: cmd_in = CMD_DETECT;
            default:   cmd_in = CMD_IRLEN;
         endcase
         phase_in       = PH_PRE;
         cnt_in         = '0;
         shift_in       = req_shift_value;
         cap_in         = '0;
         id_cnt_in      = '0;
         dev_in         = '0;
         prev_tdo_in    = 1'b0;
         len_in         = LEN_W'(len_sat);
         irlen_in       = '0;
         irlen_found_in = 1'b0;
      end
   end

   // Result register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || take) begin
            out_in = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in = res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff         <= CMD_IDLE;
         phase_ff       <= PH_PRE;
         cnt_ff         <= '0;
         shift_ff       <= '0;
         cap_ff         <= '0;
         id_cnt_ff      <= '0;
         dev_ff         <= '0;
         prev_tdo_ff    <= 1'b0;
         len_ff         <= '0;
         irlen_ff       <= '0;
         irlen_found_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         cmd_ff         <= cmd_in;
         phase_ff       <= phase_in;
         cnt_ff         <= cnt_in;
         shift_ff       <= shift_in;
         cap_ff         <= cap_in;
         id_cnt_ff      <= id_cnt_in;
         dev_ff         <= dev_in;
         prev_tdo_ff    <= prev_tdo_in;
         len_ff         <= len_in;
         irlen_ff       <= irlen_in;
         irlen_found_ff <= irlen_found_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_tms_out       = out_ff.tms_out;
   assign rsp_tdi_out       = out_ff.tdi_out;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_sequence_done = out_ff.sequence_done;
   assign rsp_report_kind   = out_ff.report_kind;
   assign rsp_report_value  = out_ff.report_value;
   assign rsp_device_index  = out_ff.device_index;
   assign rsp_end_of_chain  = out_ff.end_of_chain;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sequence_done) |-> !rsp_busy_res)
      else $error("result flags both done and busy");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_IDLE) |-> (phase_ff == PH_PRE && cnt_ff == '0))
      else $error("idle sequencer with stale phase or counter");

   a_idcode_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_kind == RPT_IDCODE) |-> (rsp_busy_res && !rsp_sequence_done))
      else $error("idcode report on a finishing tick");
`endif

endmodule

`default_nettype wire
